/* src/mfbr_pkg.sv */
package mfbr_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_TYPE    = 4'd1,
    PH_DIR     = 4'd2,
    PH_V1_SIZE = 4'd3,
    PH_V1_CMD  = 4'd4,
    PH_V2_FLAG = 4'd5,
    PH_V2_CMDL = 4'd6,
    PH_V2_CMDH = 4'd7,
    PH_V2_SIZL = 4'd8,
    PH_V2_SIZH = 4'd9,
    PH_PAYLOAD = 4'd10,
    PH_CHECK   = 4'd11
  } phase_e;

  typedef enum logic [2:0] {
    EV_HEADER  = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_GOOD    = 3'd2,
    EV_BADSUM  = 3'd3,
    EV_NOSTART = 3'd4,
    EV_BADTYPE = 3'd5,
    EV_BADDIR  = 3'd6
  } event_e;

  localparam logic [7:0] CHR_START = 8'h24;  // '$'
  localparam logic [7:0] CHR_V1    = 8'h4D;  // 'M'
  localparam logic [7:0] CHR_V2    = 8'h58;  // 'X'
  localparam logic [7:0] CHR_REQ   = 8'h3C;  // '<'
  localparam logic [7:0] CHR_RSP   = 8'h3E;  // '>'

  localparam logic [7:0] CRC_POLY  = 8'hD5;
  localparam logic [7:0] CRC_MSB   = 8'h80;

  // CRC-8 DVB-S2, one byte, MSB first
  function automatic logic [7:0] crc8_d5_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((v & CRC_MSB) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

/* src/mfbr_in_if.sv */
interface mfbr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* src/mfbr_out_if.sv */
interface mfbr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [15:0] command_id;
  logic [15:0] payload_length;
  logic        is_v2;
  logic        is_response;

  modport source (
    output valid, output event_res, output payload_byte, output command_id,
    output payload_length, output is_v2, output is_response, input ready
  );
  modport sink (
    input valid, input event_res, input payload_byte, input command_id,
    input payload_length, input is_v2, input is_response, output ready
  );
endinterface

/* src/msp_frame_byte_receiver.sv */
// Channel   Dir  Payload                                             Handshake
// byte_i    in   rx_byte[7:0]                                        valid/ready
// res_o     out  event_res, payload_byte, command_id, payload_length, valid/ready
//                is_v2, is_response
//
// One byte per cycle: the frame state and check update (v1 XOR, v2 CRC-8)
// sit between the accepted byte and the result register, one result per byte.
// A byte is taken whenever the result register is empty or being drained, so
// a stalled sink holds one result and stops intake only while it holds.
// rst_ni (async, active low) returns the parser to idle, no frame open.
module msp_frame_byte_receiver
  import mfbr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  mfbr_in_if.sink    byte_i,
  mfbr_out_if.source res_o
);

  phase_e      phase_q, phase_d;
  logic        version_q, version_d;
  logic        direction_q, direction_d;
  logic [7:0]  check_q, check_d;
  logic [15:0] command_q, command_d;
  logic [15:0] size_q, size_d;
  logic [15:0] count_q, count_d;

  logic        out_valid_q;
  event_e      event_q, event_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic [15:0] out_cmd_q, out_cmd_d;
  logic [15:0] out_len_q, out_len_d;
  logic        out_v2_q, out_v2_d;
  logic        out_rsp_q, out_rsp_d;

  logic        in_fire;
  logic [7:0]  b;
  logic [7:0]  folded;
  logic [15:0] count_inc;
  logic        frame_info;

  assign b         = byte_i.rx_byte;
  assign byte_i.ready = !out_valid_q || res_o.ready;
  assign in_fire   = byte_i.valid && byte_i.ready;
  assign folded    = version_q ? crc8_d5_step(check_q, b) : (check_q ^ b);
  assign count_inc = count_q + 16'd1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_TYPE: begin
        phase_d = (b == CHR_V1 || b == CHR_V2) ? PH_DIR : PH_IDLE;
      end
      PH_DIR: begin
        if (b == CHR_REQ || b == CHR_RSP) begin
          phase_d = version_q ? PH_V2_FLAG : PH_V1_SIZE;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_V1_SIZE: phase_d = PH_V1_CMD;
      PH_V1_CMD:  phase_d = (size_q != 16'd0) ? PH_PAYLOAD : PH_CHECK;
      PH_V2_FLAG: phase_d = PH_V2_CMDL;
      PH_V2_CMDL: phase_d = PH_V2_CMDH;
      PH_V2_CMDH: phase_d = PH_V2_SIZL;
      PH_V2_SIZL: phase_d = PH_V2_SIZH;
      PH_V2_SIZH: phase_d = ({b, size_q[7:0]} != 16'd0) ? PH_PAYLOAD : PH_CHECK;
      PH_PAYLOAD: phase_d = (count_inc >= size_q) ? PH_CHECK : PH_PAYLOAD;
      PH_CHECK:   phase_d = PH_IDLE;
      default:    phase_d = (b == CHR_START) ? PH_TYPE : PH_IDLE;
    endcase
  end

  // frame registers and result
  always_comb begin
    version_d   = version_q;
    direction_d = direction_q;
    check_d     = check_q;
    command_d   = command_q;
    size_d      = size_q;
    count_d     = count_q;
    event_d     = EV_HEADER;
    pbyte_d     = 8'h00;
    frame_info  = 1'b0;
    case (phase_q)
      PH_TYPE: begin
        if (b == CHR_V1 || b == CHR_V2) begin
          version_d = (b == CHR_V2);
        end else begin
          event_d = EV_BADTYPE;
        end
      end
      PH_DIR: begin
        if (b == CHR_REQ || b == CHR_RSP) begin
          direction_d = (b == CHR_RSP);
        end else begin
          event_d = EV_BADDIR;
        end
      end
      PH_V1_SIZE: begin
        size_d  = {8'h00, b};
        check_d = folded;
      end
      PH_V1_CMD: begin
        command_d = {8'h00, b};
        check_d   = folded;
        count_d   = 16'd0;
      end
      PH_V2_FLAG: check_d = folded;
      PH_V2_CMDL: begin
        command_d = {command_q[15:8], b};
        check_d   = folded;
      end
      PH_V2_CMDH: begin
        command_d = {b, command_q[7:0]};
        check_d   = folded;
      end
      PH_V2_SIZL: begin
        size_d  = {size_q[15:8], b};
        check_d = folded;
      end
      PH_V2_SIZH: begin
        size_d  = {b, size_q[7:0]};
        check_d = folded;
        count_d = 16'd0;
      end
      PH_PAYLOAD: begin
        check_d    = folded;
        pbyte_d    = b;
        event_d    = EV_PAYLOAD;
        frame_info = 1'b1;
        count_d    = count_inc;
      end
      PH_CHECK: begin
        event_d    = (check_q == b) ? EV_GOOD : EV_BADSUM;
        frame_info = 1'b1;
      end
      default: begin
        if (b == CHR_START) begin
          check_d   = 8'h00;
          command_d = 16'd0;
          size_d    = 16'd0;
          count_d   = 16'd0;
        end else begin
          event_d = EV_NOSTART;
        end
      end
    endcase
    out_cmd_d = frame_info ? command_q : 16'd0;
    out_len_d = frame_info ? size_q : 16'd0;
    out_v2_d  = frame_info && version_q;
    out_rsp_d = frame_info && direction_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      version_q   <= 1'b0;
      direction_q <= 1'b0;
      check_q     <= 8'h00;
      command_q   <= 16'd0;
      size_q      <= 16'd0;
      count_q     <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        version_q   <= version_d;
        direction_q <= direction_d;
        check_q     <= check_d;
        command_q   <= command_d;
        size_q      <= size_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      event_q   <= event_d;
      pbyte_q   <= pbyte_d;
      out_cmd_q <= out_cmd_d;
      out_len_q <= out_len_d;
      out_v2_q  <= out_v2_d;
      out_rsp_q <= out_rsp_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.event_res      = event_q;
  assign res_o.payload_byte   = pbyte_q;
  assign res_o.command_id     = out_cmd_q;
  assign res_o.payload_length = out_len_q;
  assign res_o.is_v2          = out_v2_q;
  assign res_o.is_response    = out_rsp_q;

`ifndef ASSERT_OFF
  a_nostart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_IDLE && b != CHR_START
    |=> res_o.valid && res_o.event_res == EV_NOSTART)
    else $error("no-start byte not reported");

  a_check_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_CHECK |=> phase_q == PH_IDLE)
    else $error("parser did not return to idle after check byte");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> count_q < size_q)
    else $error("payload count reached declared size while in payload");

  a_info_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.event_res == EV_HEADER || res_o.event_res == EV_NOSTART ||
                    res_o.event_res == EV_BADTYPE || res_o.event_res == EV_BADDIR)
    |-> res_o.command_id == 16'd0 && res_o.payload_length == 16'd0 &&
        !res_o.is_v2 && !res_o.is_response)
    else $error("frame info leaked outside frame events");
`endif

endmodule

/* tb/tb_msp_frame_byte_receiver.sv */
`timescale 1ns / 100ps

module tb_msp_frame_byte_receiver
  import mfbr_pkg::*;
;

  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  data;
    logic [15:0] cmd;
    logic [15:0] len;
    logic        v2;
    logic        rsp;
  } msp_result_t;

  // Frame tracker: follows the byte stream and queues the result each byte should produce.
  class msp_frame_scoreboard;
    phase_e      ph;
    logic        v2_f;
    logic        rsp_f;
    logic [7:0]  chk;
    logic [15:0] cmd;
    logic [15:0] size;
    logic [15:0] cnt;
    msp_result_t results_due[$];
    int          errors;

    function new();
      ph     = PH_IDLE;
      v2_f   = 1'b0;
      rsp_f  = 1'b0;
      chk    = 8'h00;
      cmd    = 16'h0000;
      size   = 16'h0000;
      cnt    = 16'h0000;
      errors = 0;
    endfunction

    function logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
      logic [7:0] v;
      v = c ^ b;
      for (int i = 0; i < 8; i++) begin
        if (v[7]) begin
          v = {v[6:0], 1'b0} ^ CRC_POLY;
        end else begin
          v = {v[6:0], 1'b0};
        end
      end
      return v;
    endfunction

    function void fold(logic [7:0] b);
      if (v2_f) begin
        chk = crc_next(chk, b);
      end else begin
        chk = chk ^ b;
      end
    endfunction

    function void open_payload();
      cnt = 16'h0000;
      if (size != 16'h0000) begin
        ph = PH_PAYLOAD;
      end else begin
        ph = PH_CHECK;
      end
    endfunction

    function logic [7:0] frame_sum();
      return chk;
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void note_byte(logic [7:0] b);
      msp_result_t e;
      bit          info;
      e    = '0;
      e.ev = EV_HEADER;
      info = 1'b0;
      case (ph)
        PH_TYPE: begin
          if (b == CHR_V1 || b == CHR_V2) begin
            v2_f = (b == CHR_V2);
            ph   = PH_DIR;
          end else begin
            e.ev = EV_BADTYPE;
            ph   = PH_IDLE;
          end
        end
        PH_DIR: begin
          if (b == CHR_REQ || b == CHR_RSP) begin
            rsp_f = (b == CHR_RSP);
            if (v2_f) begin
              ph = PH_V2_FLAG;
            end else begin
              ph = PH_V1_SIZE;
            end
          end else begin
            e.ev = EV_BADDIR;
            ph   = PH_IDLE;
          end
        end
        PH_V1_SIZE: begin
          size = {8'h00, b};
          fold(b);
          ph = PH_V1_CMD;
        end
        PH_V1_CMD: begin
          cmd = {8'h00, b};
          fold(b);
          open_payload();
        end
        PH_V2_FLAG: begin
          fold(b);
          ph = PH_V2_CMDL;
        end
        PH_V2_CMDL: begin
          cmd[7:0] = b;
          fold(b);
          ph = PH_V2_CMDH;
        end
        PH_V2_CMDH: begin
          cmd[15:8] = b;
          fold(b);
          ph = PH_V2_SIZL;
        end
        PH_V2_SIZL: begin
          size[7:0] = b;
          fold(b);
          ph = PH_V2_SIZH;
        end
        PH_V2_SIZH: begin
          size[15:8] = b;
          fold(b);
          open_payload();
        end
        PH_PAYLOAD: begin
          fold(b);
          e.data = b;
          e.ev   = EV_PAYLOAD;
          info   = 1'b1;
          cnt    = cnt + 16'd1;
          if (cnt >= size) begin
            ph = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (chk == b) begin
            e.ev = EV_GOOD;
          end else begin
            e.ev = EV_BADSUM;
          end
          info = 1'b1;
          ph   = PH_IDLE;
        end
        default: begin
          if (b == CHR_START) begin
            chk  = 8'h00;
            cmd  = 16'h0000;
            size = 16'h0000;
            cnt  = 16'h0000;
            ph   = PH_TYPE;
          end else begin
            e.ev = EV_NOSTART;
            ph   = PH_IDLE;
          end
        end
      endcase
      if (info) begin
        e.cmd = cmd;
        e.len = size;
        e.v2  = v2_f;
        e.rsp = rsp_f;
      end
      results_due.push_back(e);
    endfunction

    function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(msp_result_t act);
      msp_result_t e;
      if (results_due.size() == 0) begin
        $error("result with no byte pending: event %0d", act.ev);
        errors++;
        return;
      end
      e = results_due.pop_front();
      cmp_field("event_res", 16'(e.ev), 16'(act.ev));
      cmp_field("payload_byte", 16'(e.data), 16'(act.data));
      cmp_field("command_id", e.cmd, act.cmd);
      cmp_field("payload_length", e.len, act.len);
      cmp_field("is_v2", 16'(e.v2), 16'(act.v2));
      cmp_field("is_response", 16'(e.rsp), 16'(act.rsp));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  int   sent;

  msp_frame_scoreboard sb;

  mfbr_in_if  byte_if ();
  mfbr_out_if res_if ();

  msp_frame_byte_receiver uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_if),
    .res_o  (res_if)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Called at a rising edge; returns at the edge where the transaction completes.
  task send_byte(input logic [7:0] b);
    if (!steady && $urandom_range(99) < 10) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    byte_if.valid   <= 1'b1;
    byte_if.rx_byte <= b;
    do @(posedge clk); while (!byte_if.ready);
    sb.note_byte(b);
    sent++;
  endtask

  // cut limits how many header/payload bytes go out; the check byte follows only if cut exceeds their number
  task send_frame(input bit v2, input bit rsp, input logic [15:0] cmd, input logic [15:0] len,
                  input bit corrupt, input logic [7:0] flag, input int cut);
    logic [7:0] q[$];
    int         n;
    q = {CHR_START, v2 ? CHR_V2 : CHR_V1, rsp ? CHR_RSP : CHR_REQ};
    if (v2) begin
      q = {q, flag, cmd[7:0], cmd[15:8], len[7:0], len[15:8]};
    end else begin
      q = {q, len[7:0], cmd[7:0]};
    end
    for (int i = 0; i < len; i++) q.push_back(8'($urandom));
    n = (cut < q.size()) ? cut : q.size();
    for (int i = 0; i < n; i++) send_byte(q[i]);
    if (cut > q.size()) begin
      send_byte(sb.frame_sum() ^ (corrupt ? 8'($urandom_range(1, 255)) : 8'h00));
    end
  endtask

  task wait_results();
    byte_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    msp_result_t act;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        act.ev   = res_if.event_res;
        act.data = res_if.payload_byte;
        act.cmd  = res_if.command_id;
        act.len  = res_if.payload_length;
        act.v2   = res_if.is_v2;
        act.rsp  = res_if.is_response;
        sb.check_result(act);
      end
      res_if.ready <= steady || ($urandom_range(99) >= 10);
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int         r;
    bit         v2;
    logic [15:0] len;
    sb              = new();
    steady          = 1'b0;
    sent            = 0;
    rst_n           = 1'b0;
    byte_if.valid   = 1'b0;
    byte_if.rx_byte = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: noise, bad type, bad direction, empty v1 frame, v2 frames with bad and good check
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHR_START);
    send_byte(8'h00);
    send_byte(CHR_START);
    send_byte(CHR_V1);
    send_byte(8'hFF);
    send_frame(1'b0, 1'b0, 16'h00FF, 16'd0, 1'b0, 8'h00, 1000);
    send_frame(1'b1, 1'b1, 16'hFFFF, 16'd1, 1'b1, 8'hFF, 1000);
    send_frame(1'b1, 1'b0, 16'h0000, 16'd2, 1'b0, 8'h00, 1000);

    while (sent < 550) begin
      steady = (sent >= 200 && sent < 300);
      if (sent >= 120 && sent < 135) wait_results();
      r  = $urandom_range(99);
      v2 = 1'($urandom_range(1));
      if (r < 72) begin
        if ($urandom_range(49) == 0) begin
          len = v2 ? 16'($urandom_range(240, 270)) : 16'd255;
        end else begin
          len = 16'($urandom_range(0, 8));
        end
        send_frame(v2, 1'($urandom_range(1)), 16'($urandom), len, $urandom_range(5) == 0,
                   8'($urandom), 1000);
      end else if (r < 80) begin
        send_byte(CHR_START);
        send_byte(8'($urandom));
      end else if (r < 87) begin
        send_byte(CHR_START);
        send_byte(v2 ? CHR_V2 : CHR_V1);
        send_byte(8'($urandom));
      end else if (r < 94) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        send_frame(v2, 1'($urandom_range(1)), 16'($urandom), 16'($urandom_range(0, 6)), 1'b0,
                   8'($urandom), $urandom_range(1, 10));
      end
    end
    steady = 1'b0;

    wait_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
